// ----- rtl/sed_pkg.sv -----
// Shared types, codes and character helpers for the string escape decoder.
// No dependencies; imported by sed_core, sed_queue and string_escape_decoder_top.
`default_nettype none

package sed_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 2;
  localparam int unsigned QDepth = 3;

  localparam logic [ByteW-1:0] ChNul   = 8'h00;
  localparam logic [ByteW-1:0] ChQuote = 8'h22;
  localparam logic [ByteW-1:0] ChBslash = 8'h5C;
  localparam logic [ByteW-1:0] ChX     = 8'h78;
  localparam logic [4:0]       HexNone = 5'd16;

  typedef enum logic [5:0] {
    MODE_IDLE = 6'b000001,
    MODE_BODY = 6'b000010,
    MODE_ESC  = 6'b000100,
    MODE_HEX1 = 6'b001000,
    MODE_HEX2 = 6'b010000,
    MODE_OCT  = 6'b100000
  } mode_e;

  typedef enum logic [KindW-1:0] {
    KIND_BYTE   = 2'd0,
    KIND_CLOSE  = 2'd1,
    KIND_HEX    = 2'd2,
    KIND_UNTERM = 2'd3
  } kind_e;

  typedef struct packed {
    logic             last;
    kind_e            kind;
    logic [ByteW-1:0] value;
  } result_t;

  // Results produced by one accepted byte: cnt is 0, 1 or 2
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  // 0..15 for a hex digit, HexNone otherwise
  function automatic logic [4:0] hex_val(input logic [ByteW-1:0] c);
    logic [4:0] h;
    h = HexNone;
    if (c >= 8'h30 && c <= 8'h39) begin
      h = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h = 5'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h = 5'(c - 8'h37);
    end
    return h;
  endfunction

  function automatic logic is_oct(input logic [ByteW-1:0] c);
    return (c >= 8'h30) && (c <= 8'h37);
  endfunction

  function automatic logic [ByteW-1:0] escape_code(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] r;
    case (c)
      8'h61: r = 8'h07;   // a
      8'h62: r = 8'h08;   // b
      8'h74: r = 8'h09;   // t
      8'h6E: r = 8'h0A;   // n
      8'h76: r = 8'h0B;   // v
      8'h66: r = 8'h0C;   // f
      8'h72: r = 8'h0D;   // r
      8'h65: r = 8'h1B;   // e
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sed_core.sv -----
// Decode state machine: mode, octal digit count and accumulator registers
// with the single-pass next-state and result logic. Depends on sed_pkg.
`default_nettype none

module sed_core (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     take_i,
  input  wire logic [sed_pkg::ByteW-1:0] ch_i,
  output sed_pkg::push_t                push_o
);
  import sed_pkg::*;

  mode_e            mode_q, mode_d;
  logic [1:0]       dc_q, dc_d;
  logic [ByteW-1:0] acc_q, acc_d;

  // outcome of treating ch_i as a plain body byte
  mode_e   b_mode;
  logic    b_emit;
  result_t b_res;
  logic [4:0] h;
  logic [ByteW-1:0] oct_acc;
  push_t   p;

  always_comb begin
    b_res = '{last: 1'b0, kind: KIND_BYTE, value: ch_i};
    b_emit = 1'b1;
    b_mode = MODE_BODY;
    if (ch_i == ChNul) begin
      b_mode = MODE_IDLE;
      b_res.kind = KIND_UNTERM;
      b_res.value = '0;
    end else if (ch_i == ChQuote) begin
      b_mode = MODE_IDLE;
      b_res.kind = KIND_CLOSE;
      b_res.value = '0;
    end else if (ch_i == ChBslash) begin
      b_mode = MODE_ESC;
      b_emit = 1'b0;
    end
  end

  always_comb begin
    h = hex_val(ch_i);
    oct_acc = {acc_q[ByteW-4:0], ch_i[2:0]};
    mode_d = mode_q;
    dc_d = dc_q;
    acc_d = acc_q;
    p = '0;
    case (mode_q)
      MODE_BODY: begin
        mode_d = b_mode;
        if (b_emit) begin
          p.cnt = 2'd1;
          p.r0 = b_res;
        end
      end
      MODE_ESC: begin
        if (ch_i == ChNul) begin
          mode_d = MODE_IDLE;
          p.cnt = 2'd1;
          p.r0.kind = KIND_UNTERM;
        end else if (ch_i == ChX) begin
          mode_d = MODE_HEX1;
          acc_d = '0;
        end else if (is_oct(ch_i)) begin
          mode_d = MODE_OCT;
          acc_d = {5'd0, ch_i[2:0]};
          dc_d = 2'd1;
        end else begin
          mode_d = MODE_BODY;
          p.cnt = 2'd1;
          p.r0.value = escape_code(ch_i);
        end
      end
      MODE_HEX1: begin
        if (h == HexNone) begin
          mode_d = MODE_IDLE;
          p.cnt = 2'd1;
          p.r0.kind = KIND_HEX;
        end else begin
          acc_d = {4'd0, h[3:0]};
          mode_d = MODE_HEX2;
        end
      end
      MODE_HEX2: begin
        p.cnt = 2'd1;
        if (h == HexNone) begin
          mode_d = MODE_IDLE;
          p.r0.kind = KIND_HEX;
        end else begin
          mode_d = MODE_BODY;
          p.r0.value = {acc_q[3:0], h[3:0]};
        end
      end
      MODE_OCT: begin
        if (is_oct(ch_i) && dc_q != 2'd3) begin
          acc_d = oct_acc;
          dc_d = dc_q + 2'd1;
          if (dc_d == 2'd3) begin
            mode_d = MODE_BODY;
            p.cnt = 2'd1;
            p.r0.value = oct_acc;
          end
        end else begin
          // flush the octal value, then handle this byte as body text
          mode_d = b_mode;
          p.cnt = 2'd1;
          p.r0.value = acc_q;
          if (b_emit) begin
            p.cnt = 2'd2;
            p.r1 = b_res;
          end
        end
      end
      default: begin
        // opening quote, or any byte at all, starts the body
        mode_d = MODE_BODY;
      end
    endcase
    if (mode_d != MODE_OCT) begin
      dc_d = 2'd0;
    end
    p.r0.last = (p.cnt == 2'd1);
    p.r1.last = 1'b1;
    if (!take_i) begin
      p.cnt = 2'd0;
    end
  end

  assign push_o = p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      dc_q <= 2'd0;
      acc_q <= '0;
    end else if (take_i) begin
      mode_q <= mode_d;
      dc_q <= dc_d;
      acc_q <= acc_d;
    end
  end

  a_oct_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_OCT) |-> (dc_q == 2'd1 || dc_q == 2'd2))
    else $error("octal digit count out of range");

  a_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_OCT) |-> (dc_q == 2'd0))
    else $error("digit count held outside octal escape");

  a_two_only_oct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.cnt == 2'd2) |-> (mode_q == MODE_OCT))
    else $error("two results from a byte outside an octal escape");

endmodule

`default_nettype wire

// ----- rtl/sed_queue.sv -----
// Three-entry result queue: takes up to two results a cycle, presents one.
// Depends on sed_pkg.
`default_nettype none

module sed_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire sed_pkg::push_t  push_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output sed_pkg::result_t     head_o
);
  import sed_pkg::*;

  result_t    q_q [QDepth];
  result_t    q_d [QDepth];
  logic [1:0] cnt_q, cnt_d, cnt_p, cnt_p1;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign room_o  = (cnt_q <= 2'd1);
  assign head_o  = q_q[0];
  assign pop     = valid_o && ready_i;
  assign cnt_p   = cnt_q - {1'b0, pop};
  assign cnt_p1  = cnt_p + 2'd1;
  assign cnt_d   = cnt_p + push_i.cnt;

  always_comb begin
    for (int i = 0; i < QDepth; i++) begin
      if (pop && i < QDepth - 1) begin
        q_d[i] = q_q[i+1];
      end else begin
        q_d[i] = q_q[i];
      end
      if (push_i.cnt != 2'd0 && 2'(i) == cnt_p) begin
        q_d[i] = push_i.r0;
      end
      if (push_i.cnt == 2'd2 && 2'(i) == cnt_p1) begin
        q_d[i] = push_i.r1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> (cnt_q <= 2'd1))
    else $error("results pushed without room");

  a_pair_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt == 2'd2) |=> (cnt_q >= 2'd2))
    else $error("result pair lost");

  a_single_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt == 2'd1) |=> (cnt_q != 2'd0))
    else $error("pushed result lost");

endmodule

`default_nettype wire

// ----- rtl/string_escape_decoder_top.sv -----
// Top level of the string escape decoder: decode core and result queue.
// Depends on sed_pkg, sed_core and sed_queue.
//
//  channel  | dir | payload                              | transaction
//  s_axis   | in  | tdata[7:0] = ch                      | tvalid & tready
//  m_axis   | out | tdata[7:0] = value, tuser = kind,    | tvalid & tready
//           |     | tlast = last                         |
//
// One byte is accepted per cycle while s_axis_tready is high; its results enter the
// queue at the same edge and reach m_axis behind any waiting results. A byte that gives
// two results (end of a short octal escape) needs two transfers on the output port.
// Reset puts the decoder in idle (any byte then opens the body) and empties the queue.
// s_axis_tready is high while at most one result waits, so output stalls back up
// to the input after two held results.
`default_nettype none

module string_escape_decoder_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [sed_pkg::ByteW-1:0] s_axis_tdata,   // [7:0] ch
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [sed_pkg::ByteW-1:0]      m_axis_tdata,   // [7:0] value
  output logic [sed_pkg::KindW-1:0]      m_axis_tuser,   // [1:0] kind
  output logic                           m_axis_tlast
);
  import sed_pkg::*;

  push_t   push;
  result_t head;
  logic    take;

  assign take = s_axis_tvalid && s_axis_tready;

  sed_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .ch_i   (s_axis_tdata),
    .push_o (push)
  );

  sed_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .head_o  (head)
  );

  assign m_axis_tdata = head.value;
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

`default_nettype wire
